// File: rtl/line_position_estimator_defines.svh
// Assertion macros used by the line position estimator top level.
`ifndef LINE_POSITION_ESTIMATOR_DEFINES_SVH
`define LINE_POSITION_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line position estimator: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line position estimator: next-cycle check failed");

`endif

// File: rtl/lpe_pkg.sv
// Shared constants, codes and types of the line position estimator.
package lpe_pkg;
    localparam int NUM_SENSORS_DEF = 10;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int IDX_W    = 4;
    localparam int SAMPLE_W = 12;
    localparam int THR_W    = 13;
    localparam int LEVEL_W  = 13;
    localparam int WSUM_W   = 21;
    localparam int LSUM_W   = 16;
    localparam int POS_W    = 12;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THR_W;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_THR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR = 1'd1;
    localparam logic [THR_W-1:0] LINE_THR_RST  = 13'd2048;
    localparam logic [THR_W-1:0] NOISE_THR_RST = 13'd410;

    localparam logic MODE_CAL  = 1'b0;
    localparam logic MODE_MEAS = 1'b1;

    localparam logic [LEVEL_W-1:0] Q_ONE = 13'd4096;
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam int DIV_NW = 28;
    localparam int DIV_DW = 16;
    localparam int DIV_CW = 5;
    localparam logic [DIV_CW-1:0] NORM_STEPS = 5'd12;
    localparam logic [DIV_CW-1:0] CENT_STEPS = 5'd28;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] CLS_ZERO = 2'd0;
    localparam logic [1:0] CLS_FULL = 2'd1;
    localparam logic [1:0] CLS_DIV  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [1:0]          cls;
        logic [SAMPLE_W-1:0] num;
        logic [SAMPLE_W-1:0] den;
        logic                last;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] rem;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
        logic [DIV_CW-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;
endpackage

// File: rtl/lpe_in_if.sv
// Sample channel: valid, ready and one sensor sample per beat.
interface lpe_in_if;
    import lpe_pkg::*;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [IDX_W-1:0]    sensor_index;
    logic [SAMPLE_W-1:0] sample;
    logic                last_in_frame;

    modport source (output valid, mode, sensor_index, sample, last_in_frame, input ready);
    modport sink   (input valid, mode, sensor_index, sample, last_in_frame, output ready);
endinterface

// File: rtl/lpe_out_if.sv
// Result channel: valid, ready and one position result per beat.
interface lpe_out_if;
    import lpe_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic             line_seen;
    logic             held_extreme;

    modport source (output valid, position, line_seen, held_extreme, input ready);
    modport sink   (input valid, position, line_seen, held_extreme, output ready);
endinterface

// File: rtl/lpe_front.sv
// Front end: accepts samples, keeps the calibration table and classifies measure samples.
module lpe_front #(
    parameter int NUM_SENSORS = lpe_pkg::NUM_SENSORS_DEF,
    parameter int SAMPLE_BITS = lpe_pkg::SAMPLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpe_in_if.sink        i_sample_ch,
    input  logic          i_full,
    output logic          o_push,
    output lpe_pkg::t_item o_item
);
    import lpe_pkg::*;

    localparam int XW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int TW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    logic [XW-1:0] r_min [NUM_SENSORS];
    logic [XW-1:0] r_max [NUM_SENSORS];

    logic          accept;
    logic          in_range;
    logic [TW-1:0] tix;
    logic [XW-1:0] x;
    logic [XW-1:0] lo;
    logic [XW-1:0] hi;
    logic [XW-1:0] num;
    logic [XW-1:0] den;

    assign i_sample_ch.ready = !i_full;
    assign accept   = i_sample_ch.valid && !i_full;
    assign in_range = {1'b0, i_sample_ch.sensor_index} < (IDX_W+1)'(NUM_SENSORS);
    assign tix      = i_sample_ch.sensor_index[TW-1:0];
    assign x        = i_sample_ch.sample[XW-1:0];
    assign lo       = r_min[tix];
    assign hi       = r_max[tix];
    assign num      = x - lo;
    assign den      = hi - lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_min[k] <= '1;
                r_max[k] <= '0;
            end
        end else if (accept && i_sample_ch.mode == MODE_CAL && in_range) begin
            if (x >= hi) begin
                r_max[tix] <= x;
            end
            if (x <= lo) begin
                r_min[tix] <= x;
            end
        end
    end

    assign o_push = accept && i_sample_ch.mode == MODE_MEAS;

    always_comb begin
        o_item.idx  = i_sample_ch.sensor_index;
        o_item.last = i_sample_ch.last_in_frame;
        o_item.num  = SAMPLE_W'(num);
        o_item.den  = SAMPLE_W'(den);
        if (!in_range) begin
            o_item.cls = CLS_ZERO;
        end else if (hi <= lo || x <= lo) begin
            o_item.cls = CLS_ZERO;
        end else if (x >= hi) begin
            o_item.cls = CLS_FULL;
        end else begin
            o_item.cls = CLS_DIV;
        end
    end
endmodule

// File: rtl/lpe_fifo.sv
// Short queue of classified samples between the front end and the back end.
module lpe_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpe_pkg::t_item i_item,
    input  logic           i_pop,
    output lpe_pkg::t_item o_head,
    output logic           o_full,
    output logic           o_empty
);
    import lpe_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_full  = r_cnt == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: rtl/lpe_div.sv
// Shared restoring divider, one quotient bit per cycle.
module lpe_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpe_pkg::t_div_req i_req,
    output lpe_pkg::t_div_rsp o_rsp
);
    import lpe_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_CW-1:0] r_cnt,  n_cnt;
    logic [DIV_DW-1:0] r_rem,  n_rem;
    logic [DIV_DW-1:0] r_den,  n_den;
    logic [DIV_NW-1:0] r_num,  n_num;
    logic [DIV_NW-1:0] r_quot, n_quot;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;

    always_comb begin
        trial  = {r_rem, r_num[DIV_NW-1]};
        diff   = trial - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_num  = r_num;
        n_quot = r_quot;
        if (r_busy) begin
            n_num = {r_num[DIV_NW-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem  = diff[DIV_DW-1:0];
                n_quot = {r_quot[DIV_NW-2:0], 1'b1};
            end else begin
                n_rem  = trial[DIV_DW-1:0];
                n_quot = {r_quot[DIV_NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_rem  = i_req.rem;
            n_den  = i_req.den;
            n_num  = i_req.num;
            n_quot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_num  <= n_num;
        r_quot <= n_quot;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

// File: rtl/lpe_back.sv
// Back end: normalization, centroid sums, frame result and output register.
module lpe_back #(
    parameter int NUM_SENSORS = lpe_pkg::NUM_SENSORS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lpe_pkg::t_item            i_head,
    input  logic                      i_empty,
    output logic                      o_pop,
    input  logic [lpe_pkg::THR_W-1:0] i_line_thr,
    input  logic [lpe_pkg::THR_W-1:0] i_noise_thr,
    output lpe_pkg::t_div_req         o_div_req,
    input  lpe_pkg::t_div_rsp         i_div_rsp,
    lpe_out_if.source                 o_result_ch
);
    import lpe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NDIV = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_CDIV = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    localparam int PW = 20;
    localparam logic [POS_W-1:0] POS_EXT   = POS_W'((NUM_SENSORS - 1) * 128);
    localparam logic [POS_W-1:0] POS_EXT_N = POS_W'(-(NUM_SENSORS - 1) * 128);
    localparam logic signed [IDX_W+1:0] W2_OFF = (IDX_W+2)'(NUM_SENSORS - 1);
    localparam logic signed [WSUM_W:0] WS_HI = {2'b00, {(WSUM_W-1){1'b1}}};
    localparam logic signed [WSUM_W:0] WS_LO = {2'b11, {(WSUM_W-1){1'b0}}};

    logic [2:0]                r_state, n_state;
    logic signed [WSUM_W-1:0]  r_wsum,  n_wsum;
    logic [LSUM_W-1:0]         r_lsum,  n_lsum;
    logic                      r_any,   n_any;
    logic [POS_W-1:0]          r_prev,  n_prev;
    logic                      r_out_valid, n_out_valid;

    logic [IDX_W-1:0]          r_idx,   n_idx;
    logic                      r_last,  n_last;
    logic [LEVEL_W-1:0]        r_y,     n_y;
    logic [POS_W-1:0]          r_pos,   n_pos;
    logic                      r_held,  n_held;
    logic [POS_W-1:0]          r_out_pos,  n_out_pos;
    logic                      r_out_seen, n_out_seen;
    logic                      r_out_held, n_out_held;

    logic signed [IDX_W+1:0]   w2;
    logic signed [PW-1:0]      w2_x;
    logic signed [PW-1:0]      y_x;
    logic signed [PW-1:0]      prod;
    logic signed [WSUM_W:0]    wsum_x;
    logic [LSUM_W:0]           lsum_x;
    logic [WSUM_W:0]           mag;
    logic [DIV_NW-1:0]         cent_num;
    logic [DIV_NW-1:0]         quot;
    logic [POS_W-1:0]          cent_pos;
    logic                      out_free;

    assign w2     = $signed({1'b0, r_idx, 1'b0}) - W2_OFF;
    assign w2_x   = PW'(w2);
    assign y_x    = $signed(PW'(r_y));
    assign prod   = w2_x * y_x;
    assign wsum_x = (WSUM_W+1)'(r_wsum) + (WSUM_W+1)'(prod);
    assign lsum_x = {1'b0, r_lsum} + (LSUM_W+1)'(r_y);

    assign mag      = r_wsum[WSUM_W-1] ? (~{1'b1, r_wsum} + 1'b1) : {1'b0, r_wsum};
    assign cent_num = DIV_NW'({mag, 7'd0}) + DIV_NW'(r_lsum[LSUM_W-1:1]);
    assign quot     = i_div_rsp.quot;

    always_comb begin
        if (r_wsum[WSUM_W-1]) begin
            if (quot > DIV_NW'(POS_MIN)) begin
                cent_pos = POS_MIN;
            end else begin
                cent_pos = ~quot[POS_W-1:0] + 1'b1;
            end
        end else begin
            if (quot > DIV_NW'(POS_MAX)) begin
                cent_pos = POS_MAX;
            end else begin
                cent_pos = quot[POS_W-1:0];
            end
        end
    end

    assign o_pop    = r_state == S_IDLE && !i_empty;
    assign out_free = !r_out_valid || o_result_ch.ready;

    always_comb begin
        o_div_req.start = 1'b0;
        if (r_state == S_FIN) begin
            o_div_req.rem   = '0;
            o_div_req.num   = cent_num;
            o_div_req.den   = r_lsum;
            o_div_req.steps = CENT_STEPS;
            o_div_req.start = (r_any || r_prev == '0) && r_lsum != '0;
        end else begin
            o_div_req.rem   = DIV_DW'(i_head.num);
            o_div_req.num   = '0;
            o_div_req.den   = DIV_DW'(i_head.den);
            o_div_req.steps = NORM_STEPS;
            o_div_req.start = o_pop && i_head.cls == CLS_DIV;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wsum      = r_wsum;
        n_lsum      = r_lsum;
        n_any       = r_any;
        n_prev      = r_prev;
        n_out_valid = r_out_valid && !o_result_ch.ready;
        n_idx       = r_idx;
        n_last      = r_last;
        n_y         = r_y;
        n_pos       = r_pos;
        n_held      = r_held;
        n_out_pos   = r_out_pos;
        n_out_seen  = r_out_seen;
        n_out_held  = r_out_held;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_idx  = i_head.idx;
                    n_last = i_head.last;
                    if (i_head.cls == CLS_DIV) begin
                        n_state = S_NDIV;
                    end else begin
                        n_y     = (i_head.cls == CLS_FULL) ? Q_ONE : '0;
                        n_state = S_ACC;
                    end
                end
            end
            S_NDIV: begin
                if (i_div_rsp.done) begin
                    n_y     = quot[LEVEL_W-1:0];
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_y > i_line_thr) begin
                    n_any = 1'b1;
                end
                if (r_y > i_noise_thr) begin
                    if (wsum_x > WS_HI) begin
                        n_wsum = WS_HI[WSUM_W-1:0];
                    end else if (wsum_x < WS_LO) begin
                        n_wsum = WS_LO[WSUM_W-1:0];
                    end else begin
                        n_wsum = wsum_x[WSUM_W-1:0];
                    end
                    n_lsum = lsum_x[LSUM_W] ? '1 : lsum_x[LSUM_W-1:0];
                end
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (!r_any && r_prev != '0) begin
                    n_pos   = r_prev[POS_W-1] ? POS_EXT_N : POS_EXT;
                    n_held  = 1'b1;
                    n_state = S_EMIT;
                end else if (r_lsum == '0) begin
                    n_pos   = r_prev;
                    n_held  = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_held  = 1'b0;
                    n_state = S_CDIV;
                end
            end
            S_CDIV: begin
                if (i_div_rsp.done) begin
                    n_pos   = cent_pos;
                    n_prev  = cent_pos;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_pos;
                    n_out_seen  = r_any;
                    n_out_held  = r_held;
                    n_wsum      = '0;
                    n_lsum      = '0;
                    n_any       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wsum      <= '0;
            r_lsum      <= '0;
            r_any       <= 1'b0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wsum      <= n_wsum;
            r_lsum      <= n_lsum;
            r_any       <= n_any;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_last     <= n_last;
        r_y        <= n_y;
        r_pos      <= n_pos;
        r_held     <= n_held;
        r_out_pos  <= n_out_pos;
        r_out_seen <= n_out_seen;
        r_out_held <= n_out_held;
    end

    assign o_result_ch.valid        = r_out_valid;
    assign o_result_ch.position     = r_out_pos;
    assign o_result_ch.line_seen    = r_out_seen;
    assign o_result_ch.held_extreme = r_out_held;
endmodule

// File: rtl/line_position_estimator.sv
// Line position estimator: weighted centroid of a calibrated reflectance sensor array.
//
// Samples arrive on the sample channel, one sensor reading per beat. A calibrate
// beat widens that sensor's stored minimum and maximum in the same cycle and
// gives no result. A measure beat is queued, normalized (by a shared serial
// divider where it needs a division) and, above the noise threshold, added to
// the frame sums; the beat marked last in frame gives one result beat on the
// result channel with the position in Q.8. A measure beat that needs a division
// passes through the back end as fetch, 12 divider steps, done and accumulate,
// a clamped one as fetch and accumulate; the end of a frame adds finish, the
// 28-step centroid division and emit, or only finish and emit when the line is
// lost after a non-zero position or the sums are empty. The divider sets the
// rate. The four-entry queue lets samples keep arriving while the back end
// works, and a waiting result does not stop the queue filling. When the
// receiver stalls, the back end finishes the next frame and then holds until
// the output register is taken. Reset restores the calibration table (minimum
// all ones, maximum zero), the thresholds, the frame sums and the remembered
// position; no clearing pass. The user must make threshold writes on the plain
// write port only when the block is idle; the block itself does not enforce it.
`include "line_position_estimator_defines.svh"

module line_position_estimator #(
    parameter int NUM_SENSORS = lpe_pkg::NUM_SENSORS_DEF,
    parameter int SAMPLE_BITS = lpe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lpe_in_if.sink                         i_sample_ch,
    lpe_out_if.source                      o_result_ch,
    input  logic                           i_cfg_we,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lpe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lpe_pkg::*;

    localparam logic [POS_W-1:0] POS_EXT   = POS_W'((NUM_SENSORS - 1) * 128);
    localparam logic [POS_W-1:0] POS_EXT_N = POS_W'(-(NUM_SENSORS - 1) * 128);

    logic [THR_W-1:0] r_line_thr;
    logic [THR_W-1:0] r_noise_thr;

    logic     fifo_push;
    logic     fifo_pop;
    logic     fifo_full;
    logic     fifo_empty;
    t_item    front_item;
    t_item    fifo_head;
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     res_held;
    logic     res_at_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_thr  <= LINE_THR_RST;
            r_noise_thr <= NOISE_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINE_THR:  r_line_thr  <= i_cfg_data[THR_W-1:0];
                REG_NOISE_THR: r_noise_thr <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lpe_front #(
        .NUM_SENSORS (NUM_SENSORS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (i_sample_ch),
        .i_full      (fifo_full),
        .o_push      (fifo_push),
        .o_item      (front_item)
    );

    lpe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_item  (front_item),
        .i_pop   (fifo_pop),
        .o_head  (fifo_head),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    lpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lpe_back #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (fifo_head),
        .i_empty     (fifo_empty),
        .o_pop       (fifo_pop),
        .i_line_thr  (r_line_thr),
        .i_noise_thr (r_noise_thr),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_result_ch (o_result_ch)
    );

    assign res_held    = o_result_ch.valid && o_result_ch.held_extreme;
    assign res_at_edge = o_result_ch.position == POS_EXT || o_result_ch.position == POS_EXT_N;

    `LPE_ASSERT_IMPL(a_held_not_seen, res_held, !o_result_ch.line_seen)
    `LPE_ASSERT_IMPL(a_held_extreme, res_held, res_at_edge)
    `LPE_ASSERT_IMPL(a_div_start_idle, div_req.start, !div_rsp.busy)
    `LPE_ASSERT_NEXT(a_div_runs, div_req.start, div_rsp.busy && !div_rsp.done)
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the line position estimator: stimulus, prediction and checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpe_pkg::*;

    localparam int SENSORS    = NUM_SENSORS_DEF;
    localparam int FULL_LEVEL = 4096;
    localparam int WSUM_HI    = (1 << (WSUM_W - 1)) - 1;
    localparam int WSUM_LO    = -(1 << (WSUM_W - 1));
    localparam int LSUM_HI    = (1 << LSUM_W) - 1;
    localparam int EDGE_POS   = (SENSORS - 1) * 128;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             line_seen;
        logic             held_extreme;
    } t_position_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lpe_in_if  sample_ch ();
    lpe_out_if result_ch ();

    line_position_estimator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    t_position_beat expected_positions[$];

    int cal_lo [SENSORS];
    int cal_hi [SENSORS];
    int frame_wsum;
    int frame_lsum;
    bit frame_on_line;
    int last_pos;
    int line_thr;
    int noise_thr;

    bit tx_eager;
    bit rx_eager;
    int rx_stall;
    int hold_req;
    bit holding;

    int errors;
    int n_beats_in;
    int n_beats_out;
    int n_held;
    int n_frames;
    int n_cfg;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("Run stopped by timeout with %0d positions outstanding.",
                 expected_positions.size());
        $display("FAIL");
        $finish;
    end

    function automatic int level_of(int idx, int x);
        int lo;
        int hi;
        lo = cal_lo[idx];
        hi = cal_hi[idx];
        if (hi <= lo || x <= lo) return 0;
        if (x >= hi) return FULL_LEVEL;
        return ((x - lo) << 12) / (hi - lo);
    endfunction

    function automatic int centroid_of(int ws, int ls);
        longint mag;
        longint q;
        mag = (ws < 0) ? -longint'(ws) : longint'(ws);
        q = (mag * 128 + ls / 2) / ls;
        if (q > 2048) q = 2048;
        if (ws < 0) return -int'(q);
        return (q > 2047) ? 2047 : int'(q);
    endfunction

    task automatic predict_beat(bit mode, int idx, int x, bit is_last);
        int y;
        int w2;
        int pos;
        longint s;
        bit held;
        t_position_beat r;
        if (mode == MODE_CAL) begin
            if (idx < SENSORS) begin
                if (x >= cal_hi[idx]) cal_hi[idx] = x;
                if (x <= cal_lo[idx]) cal_lo[idx] = x;
            end
            return;
        end
        if (idx < SENSORS) begin
            y = level_of(idx, x);
            if (y > line_thr) frame_on_line = 1'b1;
            if (y > noise_thr) begin
                w2 = 2 * idx - (SENSORS - 1);
                s = longint'(frame_wsum) + longint'(w2) * longint'(y);
                if (s > WSUM_HI) s = WSUM_HI;
                if (s < WSUM_LO) s = WSUM_LO;
                frame_wsum = int'(s);
                frame_lsum = frame_lsum + y;
                if (frame_lsum > LSUM_HI) frame_lsum = LSUM_HI;
            end
        end
        if (!is_last) return;
        held = 1'b0;
        if (!frame_on_line && last_pos > 0) begin
            pos = EDGE_POS;
            held = 1'b1;
        end else if (!frame_on_line && last_pos < 0) begin
            pos = -EDGE_POS;
            held = 1'b1;
        end else if (frame_lsum == 0) begin
            pos = last_pos;
        end else begin
            pos = centroid_of(frame_wsum, frame_lsum);
            last_pos = pos;
        end
        r.position     = pos[POS_W-1:0];
        r.line_seen    = frame_on_line;
        r.held_extreme = held;
        expected_positions.push_back(r);
        n_held = n_held + held;
        n_frames++;
        frame_wsum = 0;
        frame_lsum = 0;
        frame_on_line = 1'b0;
    endtask

    // Leaves valid high after the beat so that back-to-back beats follow without valid dropping.
    task automatic send_sample(bit mode, int idx, int x, bit is_last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            @(negedge i_clk);
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        sample_ch.valid         = 1'b1;
        sample_ch.mode          = mode;
        sample_ch.sensor_index  = idx[IDX_W-1:0];
        sample_ch.sample        = x[SAMPLE_W-1:0];
        sample_ch.last_in_frame = is_last;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
        predict_beat(mode, idx, x, is_last);
        n_beats_in++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        sample_ch.valid = 1'b0;
        while (expected_positions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [CFG_IDX_W-1:0] which, int value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = which;
        i_cfg_data = value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        if (which == REG_LINE_THR) line_thr = value & 'h1FFF;
        else noise_thr = value & 'h1FFF;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        n_cfg++;
    endtask

    always @(posedge i_clk) begin
        t_position_beat got;
        t_position_beat want;
        if (i_rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            got.position     = result_ch.position;
            got.line_seen    = result_ch.line_seen;
            got.held_extreme = result_ch.held_extreme;
            n_beats_out++;
            if (expected_positions.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result beat: position %0d seen %0b held %0b",
                             $signed(got.position), got.line_seen, got.held_extreme);
            end else begin
                want = expected_positions.pop_front();
                if (got.position !== want.position || got.line_seen !== want.line_seen
                        || got.held_extreme !== want.held_extreme) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: position %0d/%0d seen %0b/%0b held %0b/%0b (exp/got)",
                                 $signed(want.position), $signed(got.position),
                                 want.line_seen, got.line_seen,
                                 want.held_extreme, got.held_extreme);
                end
            end
            rx_stall = rx_eager ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge i_clk) begin
        if (holding) begin
            result_ch.ready = 1'b0;
        end else if (rx_eager) begin
            result_ch.ready = 1'b1;
        end else if (result_ch.valid === 1'b1) begin
            if (rx_stall > 0) begin
                result_ch.ready = 1'b0;
                rx_stall--;
            end else begin
                result_ch.ready = 1'b1;
            end
        end else begin
            result_ch.ready = 1'b0;
        end
    end

    initial begin
        int n;
        holding = 1'b0;
        forever begin
            while (hold_req == 0) @(posedge i_clk);
            n = hold_req;
            @(posedge i_clk);
            hold_req = 0;
            holding = 1'b1;
            repeat (n) @(posedge i_clk);
            holding = 1'b0;
        end
    end

    function automatic int pick_sample(int idx, bit on_line);
        int lo;
        int span;
        if (idx >= SENSORS || cal_hi[idx] <= cal_lo[idx] || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 4095);
        lo = cal_lo[idx];
        span = cal_hi[idx] - lo;
        if (on_line) return cal_hi[idx] - $urandom_range(0, span / 3);
        return lo + $urandom_range(0, span / 6);
    endfunction

    task automatic test_uncalibrated();
        send_sample(MODE_MEAS, 0, 4095, 1'b0);
        send_sample(MODE_MEAS, 15, 0, 1'b1);
    endtask

    task automatic test_calibrate_extremes();
        send_sample(MODE_CAL, 0, 0, 1'b0);
        send_sample(MODE_CAL, 0, 4095, 1'b1);
        send_sample(MODE_CAL, 9, 4095, 1'b0);
        send_sample(MODE_CAL, 9, 0, 1'b0);
        send_sample(MODE_CAL, 15, 4095, 1'b1);
        send_sample(MODE_CAL, 4, 2000, 1'b0);
    endtask

    task automatic test_line_cases();
        send_sample(MODE_MEAS, 9, 4095, 1'b1);
        send_sample(MODE_MEAS, 0, 0, 1'b1);
        send_sample(MODE_MEAS, 0, 4095, 1'b0);
        send_sample(MODE_MEAS, 9, 4095, 1'b1);
        send_sample(MODE_MEAS, 0, 4095, 1'b1);
        send_sample(MODE_MEAS, 4, 2000, 1'b0);
        send_sample(MODE_MEAS, 13, 4095, 1'b1);
    endtask

    task automatic test_saturation();
        for (int k = 0; k < 32; k++) send_sample(MODE_MEAS, 9, 4095, k == 31);
        for (int k = 0; k < 32; k++) send_sample(MODE_MEAS, 0, 4095, k == 31);
    endtask

    task automatic test_threshold_extremes();
        wait_idle();
        write_threshold(REG_LINE_THR, 8191);
        write_threshold(REG_NOISE_THR, 0);
        send_sample(MODE_MEAS, 9, 2048, 1'b1);
        wait_idle();
        write_threshold(REG_LINE_THR, 0);
        write_threshold(REG_NOISE_THR, 4096);
        send_sample(MODE_MEAS, 0, 1, 1'b0);
        send_sample(MODE_MEAS, 9, 4095, 1'b1);
        wait_idle();
        write_threshold(REG_LINE_THR, 4096);
        write_threshold(REG_NOISE_THR, 8191);
        send_sample(MODE_MEAS, 9, 4095, 1'b1);
        wait_idle();
        write_threshold(REG_LINE_THR, LINE_THR_RST);
        write_threshold(REG_NOISE_THR, NOISE_THR_RST);
    endtask

    task automatic calibrate_sweep();
        int lo;
        int hi;
        for (int i = 0; i < SENSORS; i++) begin
            lo = $urandom_range(0, 1200);
            hi = $urandom_range(2500, 4095);
            if ($urandom_range(0, 7) == 0) begin
                send_sample(MODE_CAL, i, lo, $urandom_range(0, 1));
            end else if ($urandom_range(0, 1)) begin
                send_sample(MODE_CAL, i, lo, $urandom_range(0, 1));
                send_sample(MODE_CAL, i, hi, $urandom_range(0, 1));
            end else begin
                send_sample(MODE_CAL, i, hi, $urandom_range(0, 1));
                send_sample(MODE_CAL, i, lo, $urandom_range(0, 1));
            end
        end
    endtask

    task automatic send_clean_frame();
        int centre;
        int width;
        int idx;
        bit reverse;
        centre  = ($urandom_range(0, 5) == 0) ? -10 : $urandom_range(0, SENSORS - 1);
        width   = $urandom_range(0, 1);
        reverse = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < SENSORS; i++) begin
            idx = reverse ? SENSORS - 1 - i : i;
            send_sample(MODE_MEAS, idx,
                        pick_sample(idx, (idx - centre <= width) && (centre - idx <= width)),
                        i == SENSORS - 1);
        end
    endtask

    task automatic send_random_frame();
        int kind;
        int count;
        int idx;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            send_sample($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 4095),
                        $urandom_range(0, 1));
        end else if (kind == 1) begin
            count = $urandom_range(1, 12);
            for (int k = 0; k < count; k++) begin
                idx = $urandom_range(0, 15);
                send_sample(MODE_MEAS, idx, pick_sample(idx, $urandom_range(0, 1)),
                            k == count - 1);
            end
        end else if (kind == 2) begin
            count = $urandom_range(1, 4);
            for (int k = 0; k < count; k++)
                send_sample(MODE_CAL, $urandom_range(0, 15), $urandom_range(0, 4095),
                            $urandom_range(0, 1));
        end else begin
            send_clean_frame();
        end
    endtask

    task automatic pick_thresholds();
        int v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 4096;
            2: v = 8191;
            default: v = $urandom_range(1000, 3600);
        endcase
        write_threshold(REG_LINE_THR, v);
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 4096;
            default: v = $urandom_range(0, 1500);
        endcase
        write_threshold(REG_NOISE_THR, v);
    endtask

    task automatic test_backpressure();
        wait_idle();
        tx_eager = 1'b1;
        rx_eager = 1'b0;
        hold_req = 400;
        for (int f = 0; f < 4; f++) send_clean_frame();
        tx_eager = 1'b0;
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 7; p++) begin
            wait_idle();
            if (p > 0) pick_thresholds();
            if (p == 0 || $urandom_range(0, 2) == 0) calibrate_sweep();
            tx_eager = (p == 3) || ($urandom_range(0, 3) == 0);
            rx_eager = (p == 3) || ($urandom_range(0, 3) == 0);
            for (int f = 0; f < 10; f++) send_random_frame();
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_LINE_THR;
        i_cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.mode = MODE_CAL;
        sample_ch.sensor_index = '0;
        sample_ch.sample = '0;
        sample_ch.last_in_frame = 1'b0;
        result_ch.ready = 1'b0;
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        rx_stall = 0;
        hold_req = 0;
        errors = 0;
        n_beats_in = 0;
        n_beats_out = 0;
        n_held = 0;
        n_frames = 0;
        n_cfg = 0;
        for (int i = 0; i < SENSORS; i++) begin
            cal_lo[i] = (1 << SAMPLE_BITS_DEF) - 1;
            cal_hi[i] = 0;
        end
        frame_wsum = 0;
        frame_lsum = 0;
        frame_on_line = 1'b0;
        last_pos = 0;
        line_thr = LINE_THR_RST;
        noise_thr = NOISE_THR_RST;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_uncalibrated();
        test_calibrate_extremes();
        test_line_cases();
        test_saturation();
        test_threshold_extremes();
        test_backpressure();
        test_random_phases();

        @(negedge i_clk);
        sample_ch.valid = 1'b0;
        guard = 0;
        while (expected_positions.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_positions.size() != 0) begin
            errors = errors + expected_positions.size();
            $display("%0d expected positions never arrived.", expected_positions.size());
        end

        $display("Sent %0d sample beats over %0d frames with %0d threshold writes.",
                 n_beats_in, n_frames, n_cfg);
        $display("Checked %0d result beats, %0d of them held extremes; %0d mismatches.",
                 n_beats_out, n_held, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: line_position_estimator.f
+incdir+rtl
rtl/lpe_pkg.sv
rtl/lpe_in_if.sv
rtl/lpe_out_if.sv
rtl/lpe_front.sv
rtl/lpe_fifo.sv
rtl/lpe_div.sv
rtl/lpe_back.sv
rtl/line_position_estimator.sv
tb/sv/tb.sv
